>>> sv/m44ms_pkg.sv
`timescale 1ns / 1ps

package m44ms_pkg;

  // Q16.16 element and matrix geometry
  localparam int unsigned DATA_W = 32;
  localparam int unsigned DIM    = 4;
  localparam int unsigned ELEMS  = DIM * DIM;
  localparam int unsigned IDX_W  = $clog2(ELEMS);
  localparam int unsigned POS_W  = $clog2(DIM);

  localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;

  typedef logic signed [DATA_W-1:0] q_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [POS_W-1:0]         pos_t;

  // Operation codes of an input transaction
  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_MUL    = 2'd2,
    OP_SCALE  = 2'd3
  } op_t;

  // Control carried alongside each product through the pipeline
  typedef struct packed {
    logic vld;
    logic first;  // opens a dot product
    logic fin;    // closes a dot product, result leaves
    logic mul;    // second operand comes from B
    pos_t row;
    pos_t col;
  } tag_t;

  // Reset contents of a matrix entry: identity
  function automatic q_t identity_elem(input idx_t idx);
    identity_elem = (idx[IDX_W-1:POS_W] == idx[POS_W-1:0]) ? Q_ONE : '0;
  endfunction

endpackage

>>> sv/m44ms_mat_store.sv
`timescale 1ns / 1ps

module m44ms_mat_store
  import m44ms_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  idx_t wr_idx,
  input  q_t   wr_data,
  input  logic rd_en,
  input  idx_t rd_idx,
  output q_t   rd_data
);

  q_t               mem [ELEMS];
  logic [ELEMS-1:0] vld_r;
  q_t               mem_q_r;
  logic             vld_q_r;
  idx_t             idx_q_r;

  // Write one element, read one element with a registered output
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_idx];
      idx_q_r <= rd_idx;
    end
  end

  // Track entries written since reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_q_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        vld_q_r <= vld_r[rd_idx];
      end
    end
  end

  // Fall back to the identity for entries never written
  assign rd_data = vld_q_r ? mem_q_r : identity_elem(idx_q_r);

endmodule

>>> sv/matrix4x4_multiply_scale_core.sv
`timescale 1ns / 1ps
// Load transactions give no result.
// Multiply: 64 reads of A and B, one product per cycle unless the output stalls;
// one result per four products. Scale: 16 products, one result per cycle unless
// the output stalls. The single multiplier sets the rate.
// Synchronous active-low reset returns both matrices to the identity at once.

module matrix4x4_multiply_scale_core
  import m44ms_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [1:0]  in_row,
  input  logic [1:0]  in_col,
  input  logic signed [31:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_row,
  output logic [1:0]  out_col,
  output logic signed [31:0] out_value,
  output logic        out_last
);

  localparam int unsigned CNT_W  = IDX_W + POS_W;
  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam int unsigned SUM_W  = PROD_W + POS_W;
  localparam int unsigned FRAC_W = DATA_W / 2;
  localparam int unsigned SHR_W  = SUM_W - FRAC_W;
  localparam logic [CNT_W-1:0] MUL_END   = CNT_W'(ELEMS * DIM - 1);
  localparam logic [IDX_W-1:0] SCALE_END = IDX_W'(ELEMS - 1);
  localparam pos_t             POS_END   = POS_W'(DIM - 1);
  localparam q_t               Q_MAX     = {1'b0, {(DATA_W-1){1'b1}}};
  localparam q_t               Q_MIN     = {1'b1, {(DATA_W-1){1'b0}}};

  op_t               op_e;
  logic              in_acc;
  logic              adv;
  logic              issue;
  logic              last_issue;
  logic              wr_a;
  logic              wr_b;
  logic              start;
  idx_t              wr_idx;
  idx_t              a_rd_idx;
  idx_t              b_rd_idx;
  q_t                a_rd;
  q_t                b_rd;
  q_t                b_op;
  logic              busy_r;
  logic              mul_r;
  logic [CNT_W-1:0]  cnt_r;
  q_t                scale_r;
  tag_t              s0_tag;
  tag_t              s1_r;
  tag_t              s2_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic signed [SUM_W-1:0]  acc_r;
  logic [SHR_W-1:0]  shr;
  q_t                sat_nxt;
  logic              out_valid_r;
  pos_t              out_row_r;
  pos_t              out_col_r;
  q_t                out_value_r;
  logic              out_last_r;

  // Handshake and decode
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = busy_r || !adv;
  assign in_acc   = in_valid && !in_stall;
  assign op_e     = op_t'(in_op);
  assign wr_idx   = {in_row, in_col};

  always_comb begin
    wr_a  = 1'b0;
    wr_b  = 1'b0;
    start = 1'b0;
    unique case (op_e)
      OP_LOAD_A: wr_a  = in_acc;
      OP_LOAD_B: wr_b  = in_acc;
      OP_MUL:    start = in_acc;
      OP_SCALE:  start = in_acc;
      default:   start = 1'b0;
    endcase
  end

  // Sequence the reads: multiply walks {row, col, term}, scale walks the elements
  assign issue      = busy_r && adv;
  assign last_issue = mul_r ? (cnt_r == MUL_END) : (cnt_r[IDX_W-1:0] == SCALE_END);
  assign a_rd_idx   = mul_r ? {cnt_r[CNT_W-1:IDX_W], cnt_r[POS_W-1:0]} : cnt_r[IDX_W-1:0];
  assign b_rd_idx   = {cnt_r[POS_W-1:0], cnt_r[IDX_W-1:POS_W]};

  always_comb begin
    s0_tag.vld   = issue;
    s0_tag.first = !mul_r || (cnt_r[POS_W-1:0] == '0);
    s0_tag.fin   = !mul_r || (cnt_r[POS_W-1:0] == POS_END);
    s0_tag.mul   = mul_r;
    s0_tag.row   = mul_r ? cnt_r[CNT_W-1:IDX_W] : cnt_r[IDX_W-1:POS_W];
    s0_tag.col   = mul_r ? cnt_r[IDX_W-1:POS_W] : cnt_r[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (issue) begin
      busy_r <= !last_issue;
      cnt_r  <= cnt_r + 1'b1;
    end
  end

  // Hold the operation and scale factor for the whole run
  always_ff @(posedge clk) begin
    if (start) begin
      mul_r   <= (op_e == OP_MUL);
      scale_r <= in_value;
    end
  end

  m44ms_mat_store u_mat_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_a),
    .wr_idx  (wr_idx),
    .wr_data (in_value),
    .rd_en   (issue),
    .rd_idx  (a_rd_idx),
    .rd_data (a_rd)
  );

  m44ms_mat_store u_mat_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_b),
    .wr_idx  (wr_idx),
    .wr_data (in_value),
    .rd_en   (issue),
    .rd_idx  (b_rd_idx),
    .rd_data (b_rd)
  );

  // Advance the control tags with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
    end else if (adv) begin
      s1_r <= s0_tag;
      s2_r <= s1_r;
    end
  end

  // Multiply stage
  assign b_op     = s1_r.mul ? b_rd : scale_r;
  assign prod_nxt = PROD_W'(a_rd) * PROD_W'(b_op);

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
    end
  end

  // Accumulate exactly, then floor to Q16.16 and saturate
  assign sum_nxt = (s2_r.first ? SUM_W'(0) : acc_r) + SUM_W'(prod_r);
  assign shr     = sum_nxt[SUM_W-1:FRAC_W];

  always_comb begin
    if (&shr[SHR_W-1:DATA_W-1] || ~|shr[SHR_W-1:DATA_W-1]) begin
      sat_nxt = shr[DATA_W-1:0];
    end else if (shr[SHR_W-1]) begin
      sat_nxt = Q_MIN;
    end else begin
      sat_nxt = Q_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_r.vld) begin
      acc_r <= sum_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_r.vld && s2_r.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_r.vld && s2_r.fin) begin
      out_row_r   <= s2_r.row;
      out_col_r   <= s2_r.col;
      out_value_r <= sat_nxt;
      out_last_r  <= (s2_r.row == POS_END) && (s2_r.col == POS_END);
    end
  end

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

  // Checks
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> in_stall)
    else $error("input taken while a run is in progress");

  a_start_arms_run: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> (busy_r && cnt_r == '0))
    else $error("compute transaction did not start a run");

  a_load_not_during_read: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_a || wr_b) |-> !issue)
    else $error("matrix write coincides with a read issue");

  a_accum_only_multiply: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_r.vld && !s2_r.first) |-> s2_r.mul)
    else $error("scale product accumulated into a previous sum");

  a_last_at_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_row_r == POS_END && out_col_r == POS_END))
    else $error("last marker away from the final element");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import m44ms_pkg::*;

  localparam q_t Q_MAX          = 32'sh7FFF_FFFF;
  localparam q_t Q_MIN          = 32'sh8000_0000;
  localparam q_t Q_ULP_NEG      = 32'shFFFF_FFFF;
  localparam int RANDOM_PER_PH  = 76;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 40;
  localparam int LIMIT_NS       = 2_000_000;

  // One element of a result run
  typedef struct {
    pos_t row;
    pos_t col;
    q_t   value;
    logic last;
  } elem_t;

  // Shadow copy of both matrices plus the queue of elements still owed by the block
  class matrix_product_board;
    q_t    mat_a[ELEMS];
    q_t    mat_b[ELEMS];
    elem_t owed[$];
    int    errors  = 0;
    int    checked = 0;
    int    clamped = 0;
    int    loads   = 0;
    int    muls    = 0;
    int    scales  = 0;

    function new();
      for (int i = 0; i < ELEMS; i++) begin
        mat_a[i] = ((i / DIM) == (i % DIM)) ? Q_ONE : '0;
        mat_b[i] = mat_a[i];
      end
    endfunction

    // Floor the exact Q32.32 value to Q16.16, then clamp to the 32-bit range
    function q_t floor_clamp(logic signed [67:0] exact);
      logic signed [67:0] shifted;
      shifted = exact >>> 16;
      if (shifted > 68'sd2147483647) begin
        clamped++;
        return Q_MAX;
      end
      if (shifted < -68'sd2147483648) begin
        clamped++;
        return Q_MIN;
      end
      return q_t'(shifted[31:0]);
    endfunction

    // Apply an accepted transaction to the shadow state and queue its elements
    function void note_transaction(op_t op, pos_t row, pos_t col, q_t value);
      logic signed [67:0] acc;
      logic signed [67:0] lhs;
      logic signed [67:0] rhs;
      elem_t              e;
      case (op)
        OP_LOAD_A: begin
          mat_a[{row, col}] = value;
          loads++;
        end
        OP_LOAD_B: begin
          mat_b[{row, col}] = value;
          loads++;
        end
        default: begin
          if (op == OP_MUL) muls++;
          else scales++;
          for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
              acc = '0;
              if (op == OP_MUL) begin
                for (int j = 0; j < DIM; j++) begin
                  lhs = mat_a[r * DIM + j];
                  rhs = mat_b[j * DIM + c];
                  acc += lhs * rhs;
                end
              end else begin
                lhs = mat_a[r * DIM + c];
                rhs = value;
                acc = lhs * rhs;
              end
              e.row   = pos_t'(r);
              e.col   = pos_t'(c);
              e.value = floor_clamp(acc);
              e.last  = (r == DIM - 1) && (c == DIM - 1);
              owed.push_back(e);
            end
          end
        end
      endcase
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("%0t ns: %s", $time, msg);
    endtask

    // Compare one accepted element with the oldest owed one
    task check_element(pos_t row, pos_t col, q_t value, logic last);
      elem_t want;
      if (owed.size() == 0) begin
        report_mismatch($sformatf("unexpected element (%0d,%0d) = %h", row, col, value));
        return;
      end
      want = owed.pop_front();
      checked++;
      if (row !== want.row)
        report_mismatch($sformatf("out_row %0d, expected %0d", row, want.row));
      if (col !== want.col)
        report_mismatch($sformatf("out_col %0d, expected %0d", col, want.col));
      if (value !== want.value)
        report_mismatch($sformatf("out_value %h at (%0d,%0d), expected %h",
                                  value, want.row, want.col, want.value));
      if (last !== want.last)
        report_mismatch($sformatf("out_last %b at (%0d,%0d), expected %b",
                                  last, want.row, want.col, want.last));
    endtask
  endclass

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [1:0] in_op     = '0;
  logic [1:0] in_row    = '0;
  logic [1:0] in_col    = '0;
  q_t         in_value  = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_row;
  logic [1:0] out_col;
  q_t         out_value;
  logic       out_last;

  int   send_idle_pct = 24;
  int   recv_idle_pct = 56;
  int   phase         = 0;
  logic hold_on       = 1'b0;

  matrix_product_board board = new();

  matrix4x4_multiply_scale_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_op     (in_op),
    .in_row    (in_row),
    .in_col    (in_col),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_value (out_value),
    .out_last  (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Stall the result channel at random, or solidly during the hold-off
  always @(posedge clk) begin
    out_stall <= hold_on || ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Hold off the receiver for a long stretch once the busy phase starts
  initial begin
    wait (phase == 2);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  // Check results before noting inputs taken at the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) board.check_element(out_row, out_col, out_value, out_last);
      if (in_valid && !in_stall)
        board.note_transaction(op_t'(in_op), in_row, in_col, in_value);
    end
  end

  // Offer one transaction, idling first at random, and hold it until taken
  task send_transaction(op_t op, pos_t row, pos_t col, q_t value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_row   <= row;
    in_col   <= col;
    in_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Mix of full-range, small (within +/-4), extreme, shifted and whole-number values
  function automatic q_t pick_value();
    q_t tmp;
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: begin
        tmp = $urandom_range(0, 32'h0008_0000);
        return tmp - 32'sh0004_0000;
      end
      2: begin
        case ($urandom_range(0, 5))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return Q_ULP_NEG;
          3: return Q_ONE;
          4: return 32'sh0000_0001;
          default: return '0;
        endcase
      end
      3: begin
        tmp = $urandom;
        return tmp >>> $urandom_range(6, 24);
      end
      default: begin
        tmp = $urandom_range(0, 16);
        return (tmp - 32'sd8) <<< 16;
      end
    endcase
  endfunction

  task send_random();
    int   pick;
    op_t  op;
    pick = $urandom_range(0, 99);
    if (pick < 35)      op = OP_LOAD_A;
    else if (pick < 70) op = OP_LOAD_B;
    else if (pick < 85) op = OP_MUL;
    else                op = OP_SCALE;
    send_transaction(op, pos_t'($urandom_range(0, 3)), pos_t'($urandom_range(0, 3)),
                     pick_value());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Identity after reset, with row and col on compute transactions ignored
    send_transaction(OP_MUL,   2'd3, 2'd2, Q_MAX);
    send_transaction(OP_SCALE, 2'd1, 2'd1, Q_MAX);
    send_transaction(OP_SCALE, 2'd0, 2'd0, Q_MIN);
    // Corners and two inner entries of both matrices at the extremes
    send_transaction(OP_LOAD_A, 2'd0, 2'd0, Q_MAX);
    send_transaction(OP_LOAD_A, 2'd3, 2'd3, Q_MIN);
    send_transaction(OP_LOAD_A, 2'd1, 2'd2, Q_ULP_NEG);
    send_transaction(OP_LOAD_A, 2'd2, 2'd1, 32'sh0000_0001);
    send_transaction(OP_LOAD_B, 2'd0, 2'd0, Q_MAX);
    send_transaction(OP_LOAD_B, 2'd3, 2'd3, Q_MIN);
    send_transaction(OP_LOAD_B, 2'd2, 2'd1, -Q_ONE);
    send_transaction(OP_LOAD_B, 2'd1, 2'd2, 32'sh0001_8000);
    // Clamping both ways and flooring of negative fractions
    send_transaction(OP_MUL,   2'd0, 2'd0, '0);
    send_transaction(OP_SCALE, 2'd0, 2'd0, Q_MIN);
    send_transaction(OP_SCALE, 2'd0, 2'd0, Q_ULP_NEG);
    send_transaction(OP_SCALE, 2'd0, 2'd0, '0);
    send_transaction(OP_SCALE, 2'd0, 2'd0, Q_ONE);
    // Full row and column at maximum so the exact sum exceeds 64 bits
    send_transaction(OP_LOAD_A, 2'd0, 2'd1, Q_MAX);
    send_transaction(OP_LOAD_A, 2'd0, 2'd2, Q_MAX);
    send_transaction(OP_LOAD_A, 2'd0, 2'd3, Q_MAX);
    send_transaction(OP_LOAD_B, 2'd1, 2'd0, Q_MAX);
    send_transaction(OP_LOAD_B, 2'd2, 2'd0, Q_MAX);
    send_transaction(OP_LOAD_B, 2'd3, 2'd0, Q_MAX);
    send_transaction(OP_MUL,    2'd1, 2'd3, '0);

    // Random traffic under three idling patterns
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle_pct <= 24;
          recv_idle_pct <= 56;
        end
        1: begin
          send_idle_pct <= 56;
          recv_idle_pct <= 24;
        end
        default: begin
          send_idle_pct <= 0;
          recv_idle_pct <= 0;
        end
      endcase
      phase <= p;
      for (int n = 0; n < RANDOM_PER_PH; n++) send_random();
    end
    in_valid <= 1'b0;

    // Drain the owed elements, then watch for strays
    while (board.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d loads, %0d multiplies and %0d scales under three idling mixes.",
             board.loads, board.muls, board.scales);
    $display("%0d elements compared, %0d of them clamped; %0d mismatches.",
             board.checked, board.clamped, board.errors);
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Give up if the block hangs
  initial begin
    #(LIMIT_NS);
    $display("Timed out with %0d elements still owed.", board.owed.size());
    $display("FAILURE");
    $finish;
  end

endmodule
